### sv/wpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types, codes and lookup tables of the weighted patch distance block.
// ----------------------------------------------------------------------------
package wpd_pkg;

   localparam int NODE_W       = 9;
   localparam int SAMPLE_W     = 16;
   localparam int CAND_W       = 3;
   localparam int DIST_W       = 40;
   localparam int DSUM_W       = 64;
   localparam int WSUM_W       = 48;
   localparam int DIV_W        = 50;
   localparam int SQ_W         = 34;
   localparam int D2C_W        = 20;
   localparam int GAIN_W       = 16;
   localparam int CW_W         = 17;
   localparam int REQ_DATA_W   = 128;
   localparam int RSP_DATA_W   = 48;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int DIV_STEPS    = 64;
   localparam int DIV_CNT_W    = 6;
   localparam logic [1:0] MAX_CHANNELS = 2'd3;
   localparam logic signed [SAMPLE_W-1:0] UNKNOWN_LIMIT = -16'sd4096;

   typedef enum logic [1:0] {
      FN_LOAD   = 2'd0,
      FN_CENTRE = 2'd1,
      FN_SAMPLE = 2'd2,
      FN_END    = 2'd3
   } func_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_REF_CHANNEL   = 2'd1,
      CSR_COLOR_GAIN    = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_type;

   typedef struct packed {
      logic [1:0]        channel_count;
      logic signed [2:0] ref_chan;
      logic [GAIN_W-1:0] color_gain;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic sq;
      logic tmul;
      logic frac;
      logic cwgt;
      logic ewgt;
      logic prod;
      logic acc;
      logic div_load;
      logic div_step;
      logic finish;
      logic emit;
   } cmd_type;

   // exp(-n) in Q1.16 for n = 0..11.
   function automatic logic [CW_W-1:0] exp_int(input logic [3:0] n);
      logic [CW_W-1:0] v;
      begin
         unique case (n)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd24109;
            4'd2:    v = 17'd8869;
            4'd3:    v = 17'd3263;
            4'd4:    v = 17'd1200;
            4'd5:    v = 17'd442;
            4'd6:    v = 17'd162;
            4'd7:    v = 17'd60;
            4'd8:    v = 17'd22;
            4'd9:    v = 17'd8;
            4'd10:   v = 17'd3;
            4'd11:   v = 17'd1;
            default: v = 17'd0;
         endcase
         return v;
      end
   endfunction

   // exp(-i/16) in Q1.16 for i = 0..16.
   function automatic logic [CW_W-1:0] exp_frac(input logic [4:0] i);
      logic [CW_W-1:0] v;
      begin
         unique case (i)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd61566;
            5'd2:    v = 17'd57836;
            5'd3:    v = 17'd54332;
            5'd4:    v = 17'd51039;
            5'd5:    v = 17'd47947;
            5'd6:    v = 17'd45042;
            5'd7:    v = 17'd42313;
            5'd8:    v = 17'd39749;
            5'd9:    v = 17'd37341;
            5'd10:   v = 17'd35079;
            5'd11:   v = 17'd32954;
            5'd12:   v = 17'd30957;
            5'd13:   v = 17'd29081;
            5'd14:   v = 17'd27319;
            5'd15:   v = 17'd25666;
            5'd16:   v = 17'd24109;
            default: v = 17'd0;
         endcase
         return v;
      end
   endfunction

endpackage
`default_nettype wire

### sv/wpd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

### sv/wpd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_ctrl
// Sequencer that steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
module wpd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic [1:0]       req_tuser,
   input  wire logic             req_tlast,
   output logic                  req_tready,
   input  wire logic             out_free,
   output wpd_pkg::cmd_type      cmd
);
   import wpd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_TMUL, ST_FRAC, ST_CWGT, ST_EWGT, ST_PROD, ST_ACC,
      ST_DIVLD, ST_DIV, ST_FINISH, ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic                   end_ff, end_in;
   logic                   last_ff, last_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               end_in      = (func_type'(req_tuser) == FN_END);
               last_in     = req_tlast;
               if (func_type'(req_tuser) == FN_SAMPLE || func_type'(req_tuser) == FN_END) begin
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ:   begin cmd.sq   = 1'b1; state_in = ST_TMUL; end
         ST_TMUL: begin cmd.tmul = 1'b1; state_in = ST_FRAC; end
         ST_FRAC: begin cmd.frac = 1'b1; state_in = ST_CWGT; end
         ST_CWGT: begin cmd.cwgt = 1'b1; state_in = ST_EWGT; end
         ST_EWGT: begin cmd.ewgt = 1'b1; state_in = ST_PROD; end
         ST_PROD: begin cmd.prod = 1'b1; state_in = ST_ACC;  end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = end_ff ? ST_DIVLD : ST_IDLE;
         end
         ST_DIVLD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         end_ff   <= 1'b0;
         last_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         end_ff   <= end_in;
         last_ff  <= last_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### sv/wpd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_dp
// Datapath: weight store, node distance terms, sums, divider, best pair.
// ----------------------------------------------------------------------------
module wpd_dp #(
   parameter int GRID_NODES = 512
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wpd_pkg::cmd_type                     cmd,
   input  wpd_pkg::cfg_type                     cfg,
   input  wire logic [wpd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [1:0]                      req_tuser,
   output logic      [wpd_pkg::DIST_W-1:0]      best_distance,
   output logic      [wpd_pkg::CAND_W-1:0]      best_target,
   output logic      [wpd_pkg::CAND_W-1:0]      best_source,
   output logic                                 found
);
   import wpd_pkg::*;

   localparam int AW = $clog2(GRID_NODES);

   // Request fields.
   logic [NODE_W-1:0]                 node_in;
   logic signed [SAMPLE_W-1:0]        src_in [3];
   logic signed [SAMPLE_W-1:0]        tgt_in [3];
   logic [SAMPLE_W-1:0]               weight_in;
   logic [CAND_W-1:0]                 tcand_in, scand_in;
   logic                              in_range;

   assign node_in   = req_tdata[8:0];
   assign src_in[0] = req_tdata[24:9];
   assign src_in[1] = req_tdata[40:25];
   assign src_in[2] = req_tdata[56:41];
   assign tgt_in[0] = req_tdata[72:57];
   assign tgt_in[1] = req_tdata[88:73];
   assign tgt_in[2] = req_tdata[104:89];
   assign weight_in = req_tdata[120:105];
   assign tcand_in  = req_tdata[123:121];
   assign scand_in  = req_tdata[126:124];
   assign in_range  = (32'(node_in) < 32'(GRID_NODES));

   logic [SAMPLE_W-1:0] rdata;

   wpd_ram #(.WIDTH(SAMPLE_W), .DEPTH(GRID_NODES)) u_weights (
      .clock (clock),
      .we    (cmd.capture && func_type'(req_tuser) == FN_LOAD && in_range),
      .waddr (AW'(node_in)),
      .wdata (weight_in),
      .re    (cmd.capture),
      .raddr (AW'(node_in)),
      .rdata (rdata)
   );

   // Channel selection.
   logic [1:0] nch;
   logic       all_ch;
   logic [1:0] used;
   logic [2:0] ch_mask;

   always_comb begin
      nch = cfg.channel_count;
      if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
      if (nch == 2'd0) nch = 2'd1;
      all_ch = cfg.ref_chan[2] || ({1'b0, cfg.ref_chan[1:0]} >= {1'b0, nch});
      used   = all_ch ? nch : 2'd1;
      for (int k = 0; k < 3; k++) begin
         ch_mask[k] = all_ch ? (k < int'(nch)) : (cfg.ref_chan[1:0] == 2'(k));
      end
   end

   // Captured request.
   logic signed [SAMPLE_W-1:0] src_ff [3];
   logic signed [SAMPLE_W-1:0] tgt_ff [3];
   logic signed [SAMPLE_W-1:0] centre_ff [3];
   logic [CAND_W-1:0]          tcand_ff, scand_ff;
   logic                       range_ff, known_ff;

   // Node pipeline registers.
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic [D2C_W-1:0]    d2_ff, d2_in;
   logic                big_ff, big_in;
   logic [SAMPLE_W-1:0] w_ff;
   logic [35:0]         t_ff;
   logic [CW_W-1:0]     ef_ff, ef_in;
   logic [3:0]          n_ff;
   logic [CW_W-1:0]     cw_ff, cw_in;
   logic [SAMPLE_W-1:0] ew_ff;
   logic [49:0]         add_ff;

   always_comb begin
      logic [SAMPLE_W:0] da, db;
      logic [SQ_W-1:0]   d2_full;
      sq_in   = '0;
      d2_full = '0;
      for (int k = 0; k < 3; k++) begin
         da = {src_ff[k][SAMPLE_W-1], src_ff[k]} - {tgt_ff[k][SAMPLE_W-1], tgt_ff[k]};
         db = {centre_ff[k][SAMPLE_W-1], centre_ff[k]} - {tgt_ff[k][SAMPLE_W-1], tgt_ff[k]};
         if (da[SAMPLE_W]) da = -da;
         if (db[SAMPLE_W]) db = -db;
         if (ch_mask[k]) begin
            sq_in   = sq_in + SQ_W'(32'(da[SAMPLE_W-1:0]) * 32'(da[SAMPLE_W-1:0]));
            d2_full = d2_full + SQ_W'(32'(db[SAMPLE_W-1:0]) * 32'(db[SAMPLE_W-1:0]));
         end
      end
      // Beyond 2^20 the exponent argument is at least 12 for any nonzero gain.
      d2_in  = d2_full[D2C_W-1:0];
      big_in = |d2_full[SQ_W-1:D2C_W];
   end

   always_comb begin
      logic [CW_W-1:0] fa, fb, dfr;
      logic [28:0]     p;
      fa    = exp_frac({1'b0, t_ff[15:12]});
      fb    = exp_frac(5'({1'b0, t_ff[15:12]} + 5'd1));
      dfr   = fa - fb;
      p     = 29'(dfr) * 29'(t_ff[11:0]);
      ef_in = fa - CW_W'(p[28:12]);
   end

   always_comb begin
      logic [34:0] m;
      m = 35'(exp_int(n_ff)) * 35'(ef_ff) + 35'd32768;
      if (cfg.color_gain == '0) begin
         cw_in = 17'd65536;
      end else if (big_ff) begin
         cw_in = '0;
      end else begin
         cw_in = m[32:16];
      end
   end

   // Sums, divider and best pair.
   logic [DSUM_W-1:0] dsum_ff;
   logic [WSUM_W-1:0] wsum_ff;
   logic [DIV_W-1:0]  div_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DSUM_W-1:0] quo_ff;
   logic [DIST_W-1:0] best_ff;
   logic [CAND_W-1:0] btgt_ff, bsrc_ff;
   logic              found_ff;

   logic [DSUM_W:0]   dsum_add;
   logic [WSUM_W:0]   wsum_add;
   logic [DIV_W:0]    trial;
   logic [DIST_W-1:0] qsat;

   assign dsum_add = {1'b0, dsum_ff} + (DSUM_W+1)'(add_ff);
   assign wsum_add = {1'b0, wsum_ff} + (WSUM_W+1)'(ew_ff);
   assign trial    = {rem_ff, quo_ff[DSUM_W-1]};
   assign qsat     = (|quo_ff[DSUM_W-1:DIST_W]) ? '1 : quo_ff[DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int k = 0; k < 3; k++) begin
            src_ff[k] <= src_in[k];
            tgt_ff[k] <= tgt_in[k];
         end
         tcand_ff <= tcand_in;
         scand_ff <= scand_in;
         range_ff <= in_range;
         known_ff <= (src_in[0] >= UNKNOWN_LIMIT) && (tgt_in[0] >= UNKNOWN_LIMIT);
      end
      if (cmd.sq) begin
         sq_ff  <= sq_in;
         d2_ff  <= d2_in;
         big_ff <= big_in;
         w_ff   <= range_ff ? rdata : '0;
      end
      if (cmd.tmul) t_ff <= 36'(cfg.color_gain) * 36'(d2_ff);
      if (cmd.frac) begin
         ef_ff <= ef_in;
         n_ff  <= t_ff[19:16];
         // Exponent argument of 12 or more gives weight zero.
         big_ff <= big_ff || (t_ff[35:16] >= 20'd12);
      end
      if (cmd.cwgt) cw_ff <= cw_in;
      if (cmd.ewgt) ew_ff <= SAMPLE_W'((33'(w_ff) * 33'(cw_ff)) >> 16);
      if (cmd.prod) add_ff <= 50'(ew_ff) * 50'(sq_ff);
      if (cmd.div_load) begin
         div_ff <= DIV_W'(wsum_ff) * DIV_W'(used);
         rem_ff <= '0;
         quo_ff <= dsum_ff;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_ff <= DIV_W'(trial - {1'b0, div_ff});
            quo_ff <= {quo_ff[DSUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[DIV_W-1:0];
            quo_ff <= {quo_ff[DSUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) centre_ff[k] <= '0;
         dsum_ff  <= '0;
         wsum_ff  <= '0;
         best_ff  <= '1;
         btgt_ff  <= '0;
         bsrc_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.capture && func_type'(req_tuser) == FN_CENTRE) begin
            for (int k = 0; k < 3; k++) centre_ff[k] <= tgt_in[k];
         end
         if (cmd.acc && known_ff) begin
            dsum_ff <= dsum_add[DSUM_W] ? '1 : dsum_add[DSUM_W-1:0];
            wsum_ff <= wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
         end
         if (cmd.finish) begin
            if (wsum_ff != '0 && (!found_ff || qsat < best_ff)) begin
               best_ff  <= qsat;
               btgt_ff  <= tcand_ff;
               bsrc_ff  <= scand_ff;
               found_ff <= 1'b1;
            end
            dsum_ff <= '0;
            wsum_ff <= '0;
         end
         if (cmd.emit) begin
            best_ff  <= '1;
            btgt_ff  <= '0;
            bsrc_ff  <= '0;
            found_ff <= 1'b0;
         end
      end
   end

   assign best_distance = best_ff;
   assign best_target   = btgt_ff;
   assign best_source   = bsrc_ff;
   assign found         = found_ff;

endmodule
`default_nettype wire

### sv/weighted_patch_distance_min.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_patch_distance_min
// Weighted squared patch distance per candidate pair, keeps the minimum pair.
// ----------------------------------------------------------------------------
// Weight load and centre color requests finish in the idle state; a node sample runs
// the SQ, TMUL, FRAC, CWGT, EWGT, PROD and ACC states. A pair-ending sample loads
// the divider, which retires one quotient bit per cycle over 64 bits; the final pair
// hands the result over, waiting while the output register is still full. One request
// is in work at a time. Reset is synchronous; weights stay undefined until loaded;
// capture, pipeline, divider and response data registers are not reset, all else is.
module weighted_patch_distance_min #(
   parameter int GRID_NODES = 512
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // node, src_a, src_b, src_c, tgt_a, tgt_b, tgt_c, weight, target_cand,
   // source_cand, zero pad
   input  wire logic [wpd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // func
   input  wire logic [1:0]                         req_tuser,
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // smallest distance, best_target, best_source, found, zero pad
   output logic      [wpd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [wpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [wpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wpd_pkg::*;

   cfg_type           cfg_ff;
   cmd_type           cmd;
   logic              rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [DIST_W-1:0] best_distance;
   logic [CAND_W-1:0] best_target, best_source;
   logic              found;
   logic              out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= 2'd3;
         cfg_ff.ref_chan      <= -3'sd1;
         cfg_ff.color_gain    <= '0;
      end else if (csr_we) begin
         unique case (csr_type'(csr_index))
            CSR_CHANNEL_COUNT: cfg_ff.channel_count <= csr_wdata[1:0];
            CSR_REF_CHANNEL:   cfg_ff.ref_chan      <= csr_wdata[2:0];
            CSR_COLOR_GAIN:    cfg_ff.color_gain    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   wpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   wpd_dp #(.GRID_NODES(GRID_NODES)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg_ff),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .best_distance (best_distance),
      .best_target   (best_target),
      .best_source   (best_source),
      .found         (found)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {1'b0, found, best_source, best_target, best_distance};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
